### rtl/csa_pkg.sv
// Shared constants for the coalescing segregated allocator.
// Default arena geometry, transaction field widths, command and status codes.
// No dependencies.
`default_nettype none

package csa_pkg;

    // default arena geometry
    localparam int PAGE_BYTES_DEF   = 4096;
    localparam int NUM_BINS_DEF     = 16;
    localparam int NUM_PAGES_DEF    = 8;
    localparam int HEADER_BYTES_DEF = 16;
    localparam int FOOTER_BYTES_DEF = 8;

    // transaction field widths
    localparam int REQ_W    = 16;
    localparam int ADDR_IO_W = 16;
    localparam int STATUS_W = 2;

    // commands
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_BIG  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_FIT   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd3;

endpackage

`default_nettype wire

### rtl/coalescing_segregated_allocator.sv
// Coalescing segregated-fit allocator with boundary tags: top level.
// Instantiates csa_clear, csa_ctrl and two csa_ram memories; uses csa_pkg.
//
// Usage:
//   Input stream (s_axis_*): one transaction per command. tuser[0] is the
//   command (0 allocate, 1 free); tdata carries req_size and address.
//   Result stream (m_axis_*): one transaction per command. tuser carries the
//   status, tdata the payload address of a successful allocate (else 0).
//   An allocate that is too large is rejected before any memory access;
//   otherwise bin heads are probed page by page until a hit, then the
//   block is unlinked, optionally split with the rest pushed, and its tags
//   written back. A free is range-checked and then checked against its
//   tag; an accepted one locates its page, merges with free neighbors and
//   is pushed. The rate is set by the single read and single write port of
//   the tag memory, one access per cycle each, and by its registered read.
//   One command is in work at a time; s_axis_tready is high while idle.
//   Reset: after aresetn a sweep writes every tag entry, one per cycle,
//   NUM_PAGES * (HEADER_BYTES + PAGE_BYTES + FOOTER_BYTES) entries (32960 by
//   default); s_axis_tready stays low until it finishes.
//   Stall: a result waits in the output register; the next command is taken
//   meanwhile and its result is held inside until the register frees up.
`default_nettype none

module coalescing_segregated_allocator
    import csa_pkg::*;
#(
    parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
    parameter int NUM_BINS     = NUM_BINS_DEF,
    parameter int NUM_PAGES    = NUM_PAGES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int FOOTER_BYTES = FOOTER_BYTES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [15:0] req_size, [31:16] address
    input  wire logic [0:0]  s_axis_tuser,   // [0] cmd
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [15:0] payload_address
    output logic [1:0]       m_axis_tuser    // [1:0] status
);

    localparam int SPAN   = HEADER_BYTES + PAGE_BYTES + FOOTER_BYTES;
    localparam int ARENA  = NUM_PAGES * SPAN;
    localparam int ADDR_W = $clog2(ARENA);
    localparam int SIZE_W = $clog2(SPAN + 1);
    localparam int NHEAD  = NUM_PAGES * NUM_BINS;
    localparam int HIDX_W = $clog2(NHEAD);
    localparam int TAG_W  = 4 + 2 * SIZE_W + 2 * ADDR_W;
    localparam int HEAD_W = 1 + ADDR_W;

    logic                 clr_busy;
    logic                 clr_tag_we;
    logic [ADDR_W-1:0]    clr_tag_waddr;
    logic [TAG_W-1:0]     clr_tag_wdata;
    logic                 clr_head_we;
    logic [HIDX_W-1:0]    clr_head_waddr;
    logic [HEAD_W-1:0]    clr_head_wdata;

    logic                 ctl_idle;
    logic                 ctl_res_valid;
    logic                 ctl_res_ready;
    logic [STATUS_W-1:0]  ctl_status;
    logic [ADDR_IO_W-1:0] ctl_paddr;
    logic                 ctl_tag_re;
    logic [ADDR_W-1:0]    ctl_tag_raddr;
    logic                 ctl_tag_we;
    logic [ADDR_W-1:0]    ctl_tag_waddr;
    logic [TAG_W-1:0]     ctl_tag_wdata;
    logic                 ctl_head_re;
    logic [HIDX_W-1:0]    ctl_head_raddr;
    logic                 ctl_head_we;
    logic [HIDX_W-1:0]    ctl_head_waddr;
    logic [HEAD_W-1:0]    ctl_head_wdata;

    logic [TAG_W-1:0]     tag_rdata;
    logic [HEAD_W-1:0]    head_rdata;

    logic                 m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]  m_status_reg;
    logic [ADDR_IO_W-1:0] m_paddr_reg;

    logic                 s_take;

    assign s_axis_tready = ctl_idle && !clr_busy;
    assign s_take        = s_axis_tvalid && s_axis_tready;

    csa_clear #(
        .PAGE_BYTES   (PAGE_BYTES),
        .NUM_BINS     (NUM_BINS),
        .NUM_PAGES    (NUM_PAGES),
        .HEADER_BYTES (HEADER_BYTES),
        .FOOTER_BYTES (FOOTER_BYTES)
    ) u_clear (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .busy       (clr_busy),
        .tag_we     (clr_tag_we),
        .tag_waddr  (clr_tag_waddr),
        .tag_wdata  (clr_tag_wdata),
        .head_we    (clr_head_we),
        .head_waddr (clr_head_waddr),
        .head_wdata (clr_head_wdata)
    );

    csa_ctrl #(
        .PAGE_BYTES   (PAGE_BYTES),
        .NUM_BINS     (NUM_BINS),
        .NUM_PAGES    (NUM_PAGES),
        .HEADER_BYTES (HEADER_BYTES),
        .FOOTER_BYTES (FOOTER_BYTES)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (s_take),
        .in_cmd     (s_axis_tuser[0]),
        .in_req     (s_axis_tdata[15:0]),
        .in_addr    (s_axis_tdata[31:16]),
        .idle       (ctl_idle),
        .res_valid  (ctl_res_valid),
        .res_ready  (ctl_res_ready),
        .res_status (ctl_status),
        .res_paddr  (ctl_paddr),
        .tag_re     (ctl_tag_re),
        .tag_raddr  (ctl_tag_raddr),
        .tag_rdata  (tag_rdata),
        .tag_we     (ctl_tag_we),
        .tag_waddr  (ctl_tag_waddr),
        .tag_wdata  (ctl_tag_wdata),
        .head_re    (ctl_head_re),
        .head_raddr (ctl_head_raddr),
        .head_rdata (head_rdata),
        .head_we    (ctl_head_we),
        .head_waddr (ctl_head_waddr),
        .head_wdata (ctl_head_wdata)
    );

    // tag memory: sweep owns the write port until done
    csa_ram #(
        .WIDTH (TAG_W),
        .DEPTH (ARENA)
    ) u_tag_ram (
        .aclk  (aclk),
        .we    (clr_busy ? clr_tag_we : ctl_tag_we),
        .waddr (clr_busy ? clr_tag_waddr : ctl_tag_waddr),
        .wdata (clr_busy ? clr_tag_wdata : ctl_tag_wdata),
        .re    (ctl_tag_re),
        .raddr (ctl_tag_raddr),
        .rdata (tag_rdata)
    );

    // bin-head memory
    csa_ram #(
        .WIDTH (HEAD_W),
        .DEPTH (NHEAD)
    ) u_head_ram (
        .aclk  (aclk),
        .we    (clr_busy ? clr_head_we : ctl_head_we),
        .waddr (clr_busy ? clr_head_waddr : ctl_head_waddr),
        .wdata (clr_busy ? clr_head_wdata : ctl_head_wdata),
        .re    (ctl_head_re),
        .raddr (ctl_head_raddr),
        .rdata (head_rdata)
    );

    // output register
    assign ctl_res_ready = !m_valid_reg || m_axis_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (ctl_res_valid && ctl_res_ready) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl_res_valid && ctl_res_ready) begin
            m_status_reg <= ctl_status;
            m_paddr_reg  <= ctl_paddr;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tdata  = m_paddr_reg;

endmodule

`default_nettype wire

### rtl/csa_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module csa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/csa_clear.sv
// Post-reset sweep of the tag and bin-head memories.
// Writes one tag entry per cycle and, in parallel, one bin head per cycle.
// Depends on csa_pkg (default geometry).
`default_nettype none

module csa_clear
    import csa_pkg::*;
#(
    parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
    parameter int NUM_BINS     = NUM_BINS_DEF,
    parameter int NUM_PAGES    = NUM_PAGES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int FOOTER_BYTES = FOOTER_BYTES_DEF,
    localparam int SPAN   = HEADER_BYTES + PAGE_BYTES + FOOTER_BYTES,
    localparam int ARENA  = NUM_PAGES * SPAN,
    localparam int ADDR_W = $clog2(ARENA),
    localparam int SIZE_W = $clog2(SPAN + 1),
    localparam int NHEAD  = NUM_PAGES * NUM_BINS,
    localparam int HIDX_W = $clog2(NHEAD),
    localparam int TAG_W  = 4 + 2 * SIZE_W + 2 * ADDR_W,
    localparam int HEAD_W = 1 + ADDR_W
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    output logic                   busy,
    output logic                   tag_we,
    output logic [ADDR_W-1:0]      tag_waddr,
    output logic [TAG_W-1:0]       tag_wdata,
    output logic                   head_we,
    output logic [HIDX_W-1:0]      head_waddr,
    output logic [HEAD_W-1:0]      head_wdata
);

    localparam int BIN_W  = $clog2(NUM_BINS);
    localparam int HCNT_W = $clog2(NHEAD + 1);

    typedef struct packed {
        logic              f_start;
        logic              f_alloc;
        logic              f_next;
        logic              f_prev;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] next;
        logic [ADDR_W-1:0] prev;
        logic [SIZE_W-1:0] foot;
    } tag_t;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
    } head_t;

    function automatic int whole_bin(input int sz);
        int b;
        int s;
        b = 0;
        s = sz;
        while (s > 1) begin
            s = s / 2;
            b++;
        end
        if (b > NUM_BINS - 1) begin
            b = NUM_BINS - 1;
        end
        return b;
    endfunction

    localparam int WHOLE_BIN = whole_bin(SPAN);

    logic              busy_reg,  busy_next;
    logic [ADDR_W-1:0] cnt_reg,   cnt_next;
    logic [SIZE_W-1:0] off_reg,   off_next;
    logic [HCNT_W-1:0] hcnt_reg,  hcnt_next;
    logic [BIN_W-1:0]  hbin_reg,  hbin_next;
    logic [ADDR_W-1:0] hbase_reg, hbase_next;

    tag_t  tw;
    head_t hw;

    // sweep counters
    always_comb begin
        busy_next  = busy_reg;
        cnt_next   = cnt_reg;
        off_next   = off_reg;
        hcnt_next  = hcnt_reg;
        hbin_next  = hbin_reg;
        hbase_next = hbase_reg;
        if (busy_reg) begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == ADDR_W'(ARENA - 1)) begin
                busy_next = 1'b0;
            end
            if (off_reg == SIZE_W'(SPAN - 1)) begin
                off_next = '0;
            end else begin
                off_next = off_reg + 1'b1;
            end
            if (hcnt_reg != HCNT_W'(NHEAD)) begin
                hcnt_next = hcnt_reg + 1'b1;
                if (hbin_reg == BIN_W'(NUM_BINS - 1)) begin
                    hbin_next  = '0;
                    hbase_next = hbase_reg + ADDR_W'(SPAN);
                end else begin
                    hbin_next = hbin_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b1;
            cnt_reg   <= '0;
            off_reg   <= '0;
            hcnt_reg  <= '0;
            hbin_reg  <= '0;
            hbase_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            cnt_reg   <= cnt_next;
            off_reg   <= off_next;
            hcnt_reg  <= hcnt_next;
            hbin_reg  <= hbin_next;
            hbase_reg <= hbase_next;
        end
    end

    // page base holds one free whole-page block; its footer holds the span
    always_comb begin
        tw = '0;
        if (off_reg == '0) begin
            tw.f_start = 1'b1;
            tw.size    = SIZE_W'(SPAN);
        end else if (off_reg == SIZE_W'(SPAN - FOOTER_BYTES)) begin
            tw.foot = SIZE_W'(SPAN);
        end
        hw = '0;
        if (hbin_reg == BIN_W'(WHOLE_BIN)) begin
            hw.valid = 1'b1;
            hw.addr  = hbase_reg;
        end
    end

    assign busy       = busy_reg;
    assign tag_we     = busy_reg;
    assign tag_waddr  = cnt_reg;
    assign tag_wdata  = tw;
    assign head_we    = busy_reg && (hcnt_reg != HCNT_W'(NHEAD));
    assign head_waddr = hcnt_reg[HIDX_W-1:0];
    assign head_wdata = hw;

endmodule

`default_nettype wire

### rtl/csa_ctrl.sv
// Command sequencer: allocate and free by read-modify-write of the tag memory
// and the bin-head memory (one access per port per cycle, registered read).
// Depends on csa_pkg (codes, widths).
`default_nettype none

module csa_ctrl
    import csa_pkg::*;
#(
    parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
    parameter int NUM_BINS     = NUM_BINS_DEF,
    parameter int NUM_PAGES    = NUM_PAGES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int FOOTER_BYTES = FOOTER_BYTES_DEF,
    localparam int SPAN   = HEADER_BYTES + PAGE_BYTES + FOOTER_BYTES,
    localparam int ARENA  = NUM_PAGES * SPAN,
    localparam int ADDR_W = $clog2(ARENA),
    localparam int SIZE_W = $clog2(SPAN + 1),
    localparam int NHEAD  = NUM_PAGES * NUM_BINS,
    localparam int HIDX_W = $clog2(NHEAD),
    localparam int TAG_W  = 4 + 2 * SIZE_W + 2 * ADDR_W,
    localparam int HEAD_W = 1 + ADDR_W
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // command in
    input  wire logic                 start,
    input  wire logic                 in_cmd,
    input  wire logic [REQ_W-1:0]     in_req,
    input  wire logic [ADDR_IO_W-1:0] in_addr,
    output logic                      idle,
    // result out
    output logic                      res_valid,
    input  wire logic                 res_ready,
    output logic [STATUS_W-1:0]       res_status,
    output logic [ADDR_IO_W-1:0]      res_paddr,
    // tag memory
    output logic                      tag_re,
    output logic [ADDR_W-1:0]         tag_raddr,
    input  wire logic [TAG_W-1:0]     tag_rdata,
    output logic                      tag_we,
    output logic [ADDR_W-1:0]         tag_waddr,
    output logic [TAG_W-1:0]          tag_wdata,
    // bin-head memory
    output logic                      head_re,
    output logic [HIDX_W-1:0]         head_raddr,
    input  wire logic [HEAD_W-1:0]    head_rdata,
    output logic                      head_we,
    output logic [HIDX_W-1:0]         head_waddr,
    output logic [HEAD_W-1:0]         head_wdata
);

    localparam int BIN_W  = $clog2(NUM_BINS);
    localparam int PG_W   = $clog2(NUM_PAGES + 1);
    localparam int WIDE_W = ADDR_W + 1;

    typedef struct packed {
        logic              f_start;
        logic              f_alloc;
        logic              f_next;
        logic              f_prev;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] next;
        logic [ADDR_W-1:0] prev;
        logic [SIZE_W-1:0] foot;
    } tag_t;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
    } head_t;

    // sequencer states
    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_START   = 5'd1;
    localparam logic [4:0] S_A_HRD   = 5'd2;
    localparam logic [4:0] S_A_HWT   = 5'd3;
    localparam logic [4:0] S_A_TWT   = 5'd4;
    localparam logic [4:0] S_A_NEXT  = 5'd5;
    localparam logic [4:0] S_A_SPLIT = 5'd6;
    localparam logic [4:0] S_A_FIN   = 5'd7;
    localparam logic [4:0] S_A_FIN2  = 5'd8;
    localparam logic [4:0] S_U_NRD   = 5'd9;
    localparam logic [4:0] S_U_NWT   = 5'd10;
    localparam logic [4:0] S_U_PRD   = 5'd11;
    localparam logic [4:0] S_U_PWT   = 5'd12;
    localparam logic [4:0] S_P_HRD   = 5'd13;
    localparam logic [4:0] S_P_HWT   = 5'd14;
    localparam logic [4:0] S_P_TWT   = 5'd15;
    localparam logic [4:0] S_P_WR    = 5'd16;
    localparam logic [4:0] S_P_HWR   = 5'd17;
    localparam logic [4:0] S_F_CWT   = 5'd18;
    localparam logic [4:0] S_F_PG    = 5'd19;
    localparam logic [4:0] S_F_LRD   = 5'd20;
    localparam logic [4:0] S_F_LWT   = 5'd21;
    localparam logic [4:0] S_F_LTW   = 5'd22;
    localparam logic [4:0] S_F_LMG   = 5'd23;
    localparam logic [4:0] S_F_RRD   = 5'd24;
    localparam logic [4:0] S_F_RWT   = 5'd25;
    localparam logic [4:0] S_F_RMG   = 5'd26;
    localparam logic [4:0] S_F_SET   = 5'd27;
    localparam logic [4:0] S_F_FIN   = 5'd28;
    localparam logic [4:0] S_DONE    = 5'd29;

    // floor(log2(size)) clamped to the top bin
    function automatic logic [BIN_W-1:0] bin_of(input logic [SIZE_W-1:0] sz);
        int b;
        b = 0;
        for (int i = 1; i < SIZE_W; i++) begin
            if (sz[i]) begin
                b = i;
            end
        end
        if (b > NUM_BINS - 1) begin
            b = NUM_BINS - 1;
        end
        return BIN_W'(b);
    endfunction

    logic [4:0]           state_reg,  state_next;
    logic [4:0]           uret_reg,   uret_next;
    logic [4:0]           pret_reg,   pret_next;
    logic                 cmd_reg,    cmd_next;
    logic [REQ_W-1:0]     req_reg,    req_next;
    logic [ADDR_IO_W-1:0] addr_reg,   addr_next;
    logic [SIZE_W-1:0]    need_reg,   need_next;
    logic [BIN_W-1:0]     bin0_reg,   bin0_next;
    logic [BIN_W-1:0]     bin_reg,    bin_next;
    logic [PG_W-1:0]      pg_reg,     pg_next;
    logic [ADDR_W-1:0]    base_reg,   base_next;
    logic [HIDX_W-1:0]    hbase_reg,  hbase_next;
    logic [ADDR_W-1:0]    cb_reg,     cb_next;
    logic [SIZE_W-1:0]    csize_reg,  csize_next;
    logic [ADDR_W-1:0]    b_reg,      b_next;
    tag_t                 t_reg,      t_next;
    logic [ADDR_W-1:0]    pb_reg,     pb_next;
    logic [SIZE_W-1:0]    psize_reg,  psize_next;
    head_t                hv_reg,     hv_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [ADDR_IO_W-1:0] paddr_reg,  paddr_next;

    tag_t              rd_tag;
    head_t             rd_head;
    tag_t              wt;
    head_t             wh;
    logic [HIDX_W-1:0] a_hidx;
    logic [HIDX_W-1:0] u_hidx;
    logic [HIDX_W-1:0] p_hidx;
    logic [WIDE_W-1:0] end_w;
    logic [WIDE_W-1:0] rb_w;
    logic [ADDR_W-1:0] off;

    assign rd_tag  = tag_t'(tag_rdata);
    assign rd_head = head_t'(head_rdata);
    assign a_hidx  = hbase_reg + HIDX_W'(bin_reg);
    assign u_hidx  = hbase_reg + HIDX_W'(bin_of(t_reg.size));
    assign p_hidx  = hbase_reg + HIDX_W'(bin_of(psize_reg));
    assign end_w   = {1'b0, base_reg} + WIDE_W'(SPAN);
    assign rb_w    = {1'b0, cb_reg} + WIDE_W'(csize_reg);
    assign off     = cb_reg - base_reg;

    always_comb begin
        state_next  = state_reg;
        uret_next   = uret_reg;
        pret_next   = pret_reg;
        cmd_next    = cmd_reg;
        req_next    = req_reg;
        addr_next   = addr_reg;
        need_next   = need_reg;
        bin0_next   = bin0_reg;
        bin_next    = bin_reg;
        pg_next     = pg_reg;
        base_next   = base_reg;
        hbase_next  = hbase_reg;
        cb_next     = cb_reg;
        csize_next  = csize_reg;
        b_next      = b_reg;
        t_next      = t_reg;
        pb_next     = pb_reg;
        psize_next  = psize_reg;
        hv_next     = hv_reg;
        status_next = status_reg;
        paddr_next  = paddr_reg;
        tag_re      = 1'b0;
        tag_raddr   = '0;
        tag_we      = 1'b0;
        tag_waddr   = '0;
        wt          = '0;
        head_re     = 1'b0;
        head_raddr  = '0;
        head_we     = 1'b0;
        head_waddr  = '0;
        wh          = '0;

        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    cmd_next   = in_cmd;
                    req_next   = in_req;
                    addr_next  = in_addr;
                    state_next = S_START;
                end
            end

            // range checks and scan setup
            S_START: begin
                pg_next     = '0;
                base_next   = '0;
                hbase_next  = '0;
                status_next = ST_OK;
                paddr_next  = '0;
                if (cmd_reg == CMD_ALLOC) begin
                    if (32'(req_reg) > 32'(PAGE_BYTES)) begin
                        status_next = ST_TOO_BIG;
                        state_next  = S_DONE;
                    end else begin
                        need_next  = SIZE_W'(HEADER_BYTES + FOOTER_BYTES) + SIZE_W'(req_reg);
                        bin0_next  = bin_of(SIZE_W'(HEADER_BYTES + FOOTER_BYTES)
                                            + SIZE_W'(req_reg));
                        bin_next   = bin_of(SIZE_W'(HEADER_BYTES + FOOTER_BYTES)
                                            + SIZE_W'(req_reg));
                        state_next = S_A_HRD;
                    end
                end else begin
                    if (32'(addr_reg) < 32'(HEADER_BYTES) ||
                        32'(addr_reg) - 32'(HEADER_BYTES) >= 32'(ARENA)) begin
                        status_next = ST_BAD_FREE;
                        state_next  = S_DONE;
                    end else begin
                        cb_next    = ADDR_W'(32'(addr_reg) - 32'(HEADER_BYTES));
                        tag_re     = 1'b1;
                        tag_raddr  = ADDR_W'(32'(addr_reg) - 32'(HEADER_BYTES));
                        state_next = S_F_CWT;
                    end
                end
            end

            // allocate: probe bin heads page by page, bins upward
            S_A_HRD: begin
                head_re    = 1'b1;
                head_raddr = a_hidx;
                state_next = S_A_HWT;
            end

            S_A_HWT: begin
                if (!rd_head.valid) begin
                    state_next = S_A_NEXT;
                end else begin
                    tag_re     = 1'b1;
                    tag_raddr  = rd_head.addr;
                    b_next     = rd_head.addr;
                    state_next = S_A_TWT;
                end
            end

            S_A_TWT: begin
                if (rd_tag.size < need_reg) begin
                    state_next = S_A_NEXT;
                end else begin
                    t_next     = rd_tag;
                    uret_next  = S_A_SPLIT;
                    state_next = S_U_NRD;
                end
            end

            S_A_NEXT: begin
                if (bin_reg == BIN_W'(NUM_BINS - 1)) begin
                    if (pg_reg == PG_W'(NUM_PAGES - 1)) begin
                        status_next = ST_NO_FIT;
                        state_next  = S_DONE;
                    end else begin
                        pg_next    = pg_reg + 1'b1;
                        base_next  = base_reg + ADDR_W'(SPAN);
                        hbase_next = hbase_reg + HIDX_W'(NUM_BINS);
                        bin_next   = bin0_reg;
                        state_next = S_A_HRD;
                    end
                end else begin
                    bin_next   = bin_reg + 1'b1;
                    state_next = S_A_HRD;
                end
            end

            // split off the remainder when it can hold its own tags
            S_A_SPLIT: begin
                cb_next = b_reg;
                if (32'(t_reg.size) >= 32'(need_reg) + 32'(HEADER_BYTES + FOOTER_BYTES))
                begin
                    csize_next = need_reg;
                    tag_we     = 1'b1;
                    tag_waddr  = b_reg + ADDR_W'(t_reg.size) - ADDR_W'(FOOTER_BYTES);
                    wt.foot    = t_reg.size - need_reg;
                    pb_next    = b_reg + ADDR_W'(need_reg);
                    psize_next = t_reg.size - need_reg;
                    pret_next  = S_A_FIN;
                    state_next = S_P_HRD;
                end else begin
                    csize_next = t_reg.size;
                    state_next = S_A_FIN;
                end
            end

            S_A_FIN: begin
                tag_we     = 1'b1;
                tag_waddr  = cb_reg;
                wt.f_start = 1'b1;
                wt.f_alloc = 1'b1;
                wt.size    = csize_reg;
                state_next = S_A_FIN2;
            end

            S_A_FIN2: begin
                tag_we      = 1'b1;
                tag_waddr   = cb_reg + ADDR_W'(csize_reg) - ADDR_W'(FOOTER_BYTES);
                wt.foot     = csize_reg;
                status_next = ST_OK;
                paddr_next  = ADDR_IO_W'(32'(cb_reg) + 32'(HEADER_BYTES));
                state_next  = S_DONE;
            end

            // unlink t_reg (at b_reg) from its list
            S_U_NRD: begin
                if (t_reg.f_next) begin
                    tag_re     = 1'b1;
                    tag_raddr  = t_reg.next;
                    state_next = S_U_NWT;
                end else begin
                    state_next = S_U_PRD;
                end
            end

            S_U_NWT: begin
                wt         = rd_tag;
                wt.prev    = t_reg.prev;
                wt.f_prev  = t_reg.f_prev;
                tag_we     = 1'b1;
                tag_waddr  = t_reg.next;
                state_next = S_U_PRD;
            end

            S_U_PRD: begin
                if (t_reg.f_prev) begin
                    tag_re     = 1'b1;
                    tag_raddr  = t_reg.prev;
                    state_next = S_U_PWT;
                end else begin
                    head_we    = 1'b1;
                    head_waddr = u_hidx;
                    wh.valid   = t_reg.f_next;
                    wh.addr    = t_reg.f_next ? t_reg.next : '0;
                    state_next = uret_reg;
                end
            end

            S_U_PWT: begin
                wt         = rd_tag;
                wt.next    = t_reg.next;
                wt.f_next  = t_reg.f_next;
                tag_we     = 1'b1;
                tag_waddr  = t_reg.prev;
                state_next = uret_reg;
            end

            // push free block pb_reg at the head of its bin
            S_P_HRD: begin
                head_re    = 1'b1;
                head_raddr = p_hidx;
                state_next = S_P_HWT;
            end

            S_P_HWT: begin
                hv_next = rd_head;
                if (rd_head.valid) begin
                    tag_re     = 1'b1;
                    tag_raddr  = rd_head.addr;
                    state_next = S_P_TWT;
                end else begin
                    state_next = S_P_WR;
                end
            end

            S_P_TWT: begin
                wt         = rd_tag;
                wt.prev    = pb_reg;
                wt.f_prev  = 1'b1;
                tag_we     = 1'b1;
                tag_waddr  = hv_reg.addr;
                state_next = S_P_WR;
            end

            S_P_WR: begin
                wt.f_start = 1'b1;
                wt.f_next  = hv_reg.valid;
                wt.size    = psize_reg;
                wt.next    = hv_reg.valid ? hv_reg.addr : '0;
                tag_we     = 1'b1;
                tag_waddr  = pb_reg;
                state_next = S_P_HWR;
            end

            S_P_HWR: begin
                head_we    = 1'b1;
                head_waddr = p_hidx;
                wh.valid   = 1'b1;
                wh.addr    = pb_reg;
                state_next = pret_reg;
            end

            // free: block must be an allocated block start
            S_F_CWT: begin
                if (!(rd_tag.f_start && rd_tag.f_alloc)) begin
                    status_next = ST_BAD_FREE;
                    state_next  = S_DONE;
                end else begin
                    csize_next = rd_tag.size;
                    state_next = S_F_PG;
                end
            end

            // locate the page, one compare per cycle
            S_F_PG: begin
                if ({1'b0, cb_reg} >= end_w) begin
                    base_next  = base_reg + ADDR_W'(SPAN);
                    hbase_next = hbase_reg + HIDX_W'(NUM_BINS);
                end else begin
                    state_next = S_F_LRD;
                end
            end

            // left neighbor through its footer
            S_F_LRD: begin
                if (32'(off) >= 32'(FOOTER_BYTES)) begin
                    tag_re     = 1'b1;
                    tag_raddr  = cb_reg - ADDR_W'(FOOTER_BYTES);
                    state_next = S_F_LWT;
                end else begin
                    state_next = S_F_RRD;
                end
            end

            S_F_LWT: begin
                if (rd_tag.foot != '0 && 32'(rd_tag.foot) <= 32'(off)) begin
                    tag_re     = 1'b1;
                    tag_raddr  = cb_reg - ADDR_W'(rd_tag.foot);
                    b_next     = cb_reg - ADDR_W'(rd_tag.foot);
                    state_next = S_F_LTW;
                end else begin
                    state_next = S_F_RRD;
                end
            end

            S_F_LTW: begin
                if (rd_tag.f_start && !rd_tag.f_alloc) begin
                    t_next     = rd_tag;
                    uret_next  = S_F_LMG;
                    state_next = S_U_NRD;
                end else begin
                    state_next = S_F_RRD;
                end
            end

            S_F_LMG: begin
                tag_we     = 1'b1;
                tag_waddr  = cb_reg;
                csize_next = t_reg.size + csize_reg;
                cb_next    = b_reg;
                state_next = S_F_RRD;
            end

            // right neighbor inside the page
            S_F_RRD: begin
                if (rb_w < end_w) begin
                    tag_re     = 1'b1;
                    tag_raddr  = rb_w[ADDR_W-1:0];
                    b_next     = rb_w[ADDR_W-1:0];
                    state_next = S_F_RWT;
                end else begin
                    state_next = S_F_SET;
                end
            end

            S_F_RWT: begin
                if (rd_tag.f_start && !rd_tag.f_alloc) begin
                    t_next     = rd_tag;
                    uret_next  = S_F_RMG;
                    state_next = S_U_NRD;
                end else begin
                    state_next = S_F_SET;
                end
            end

            S_F_RMG: begin
                tag_we     = 1'b1;
                tag_waddr  = b_reg;
                csize_next = csize_reg + t_reg.size;
                state_next = S_F_SET;
            end

            S_F_SET: begin
                tag_we     = 1'b1;
                tag_waddr  = cb_reg + ADDR_W'(csize_reg) - ADDR_W'(FOOTER_BYTES);
                wt.foot    = csize_reg;
                pb_next    = cb_reg;
                psize_next = csize_reg;
                pret_next  = S_F_FIN;
                state_next = S_P_HRD;
            end

            S_F_FIN: begin
                status_next = ST_OK;
                paddr_next  = '0;
                state_next  = S_DONE;
            end

            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign tag_wdata  = wt;
    assign head_wdata = wh;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        uret_reg   <= uret_next;
        pret_reg   <= pret_next;
        cmd_reg    <= cmd_next;
        req_reg    <= req_next;
        addr_reg   <= addr_next;
        need_reg   <= need_next;
        bin0_reg   <= bin0_next;
        bin_reg    <= bin_next;
        pg_reg     <= pg_next;
        base_reg   <= base_next;
        hbase_reg  <= hbase_next;
        cb_reg     <= cb_next;
        csize_reg  <= csize_next;
        b_reg      <= b_next;
        t_reg      <= t_next;
        pb_reg     <= pb_next;
        psize_reg  <= psize_next;
        hv_reg     <= hv_next;
        status_reg <= status_next;
        paddr_reg  <= paddr_next;
    end

    assign idle       = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_DONE);
    assign res_status = status_reg;
    assign res_paddr  = paddr_reg;

endmodule

`default_nettype wire

### test/testbench.sv
// Self-checking testbench for coalescing_segregated_allocator.
// Predicts every result with a boundary-tag allocator model held in a scoreboard class.
// Depends on rtl/csa_pkg.sv and rtl/coalescing_segregated_allocator.sv.
`timescale 1ns / 1ps

module testbench;
    import csa_pkg::*;

    localparam int SPAN        = HEADER_BYTES_DEF + PAGE_BYTES_DEF + FOOTER_BYTES_DEF;
    localparam int ARENA       = NUM_PAGES_DEF * SPAN;
    localparam int RAND_ITEMS  = 1130;
    localparam int QUIET_AFTER = 1000;
    localparam int IDLE_LIMIT  = 100000;

    typedef struct {
        logic [STATUS_W-1:0]  status;
        logic [ADDR_IO_W-1:0] payload;
    } alloc_result_t;

    // Allocator predictor plus the queue of pending results
    class alloc_scoreboard;
        localparam int F_START = 1, F_ALLOC = 2, F_NEXT = 4, F_PREV = 8;

        int unsigned   flg[ARENA];
        int unsigned   blk_size[ARENA];
        int unsigned   nxt[ARENA];
        int unsigned   prv[ARENA];
        int unsigned   foot[ARENA];
        bit            head_ok[NUM_PAGES_DEF*NUM_BINS_DEF];
        int unsigned   head_at[NUM_PAGES_DEF*NUM_BINS_DEF];
        alloc_result_t pending_q[$];
        int unsigned   live[$];
        int unsigned   freed[$];
        int unsigned   last_payload;
        int            errors;
        int            accepted;

        function new();
            for (int i = 0; i < ARENA; i++) begin
                flg[i] = 0; blk_size[i] = 0; nxt[i] = 0; prv[i] = 0; foot[i] = 0;
            end
            for (int i = 0; i < NUM_PAGES_DEF*NUM_BINS_DEF; i++) begin
                head_ok[i] = 0; head_at[i] = 0;
            end
            for (int pg = 0; pg < NUM_PAGES_DEF; pg++) begin
                set_tags(pg*SPAN, SPAN, 0);
                push(pg*SPAN, pg);
            end
            errors = 0;
            accepted = 0;
        endfunction

        function int unsigned size_bin(int unsigned sz);
            int unsigned b;
            b = 0;
            while (sz > 1) begin
                sz >>= 1;
                b++;
            end
            return (b > NUM_BINS_DEF-1) ? NUM_BINS_DEF-1 : b;
        endfunction

        function void set_tags(int unsigned b, int unsigned sz, bit used);
            flg[b] = F_START | (used ? F_ALLOC : 0);
            blk_size[b] = sz;
            foot[b] = 0;
            foot[b+sz-FOOTER_BYTES_DEF] = sz;
        endfunction

        function void unlink(int unsigned b, int unsigned pg);
            int unsigned hi;
            hi = pg*NUM_BINS_DEF + size_bin(blk_size[b]);
            if (flg[b] & F_NEXT) begin
                prv[nxt[b]] = prv[b];
                flg[nxt[b]] = (flg[nxt[b]] & ~F_PREV) | (flg[b] & F_PREV);
            end
            if (flg[b] & F_PREV) begin
                nxt[prv[b]] = nxt[b];
                flg[prv[b]] = (flg[prv[b]] & ~F_NEXT) | (flg[b] & F_NEXT);
            end else begin
                head_ok[hi] = (flg[b] & F_NEXT) != 0;
                head_at[hi] = (flg[b] & F_NEXT) ? nxt[b] : 0;
            end
            flg[b] &= ~(F_NEXT | F_PREV);
        endfunction

        function void push(int unsigned b, int unsigned pg);
            int unsigned hi;
            hi = pg*NUM_BINS_DEF + size_bin(blk_size[b]);
            flg[b] &= ~(F_NEXT | F_PREV);
            if (head_ok[hi]) begin
                prv[head_at[hi]] = b;
                flg[head_at[hi]] |= F_PREV;
                nxt[b] = head_at[hi];
                flg[b] |= F_NEXT;
            end
            head_ok[hi] = 1;
            head_at[hi] = b;
        endfunction

        function alloc_result_t do_alloc(int unsigned req);
            alloc_result_t r;
            int unsigned need, fb, nb, hi;
            r.status = ST_NO_FIT;
            r.payload = '0;
            if (req > PAGE_BYTES_DEF) begin
                r.status = ST_TOO_BIG;
                return r;
            end
            need = HEADER_BYTES_DEF + req + FOOTER_BYTES_DEF;
            for (int pg = 0; pg < NUM_PAGES_DEF; pg++)
                for (int bn = size_bin(need); bn < NUM_BINS_DEF; bn++) begin
                    hi = pg*NUM_BINS_DEF + bn;
                    if (!head_ok[hi] || blk_size[head_at[hi]] < need) continue;
                    fb = head_at[hi];
                    unlink(fb, pg);
                    // split off the tail if it can carry its own tags
                    if (blk_size[fb] >= req + 2*HEADER_BYTES_DEF + 2*FOOTER_BYTES_DEF) begin
                        nb = fb + need;
                        set_tags(nb, blk_size[fb] - need, 0);
                        push(nb, pg);
                        blk_size[fb] = need;
                    end
                    set_tags(fb, blk_size[fb], 1);
                    r.status = ST_OK;
                    r.payload = fb + HEADER_BYTES_DEF;
                    return r;
                end
            return r;
        endfunction

        function alloc_result_t do_free(int unsigned addr);
            alloc_result_t r;
            int unsigned cb, pg, base, lsz, lb, rb;
            r.status = ST_BAD_FREE;
            r.payload = '0;
            if (addr < HEADER_BYTES_DEF || addr - HEADER_BYTES_DEF >= ARENA) return r;
            cb = addr - HEADER_BYTES_DEF;
            if ((flg[cb] & (F_START | F_ALLOC)) != (F_START | F_ALLOC)) return r;
            pg = cb / SPAN;
            base = pg * SPAN;
            // merge with a free left neighbor
            if (cb - base >= FOOTER_BYTES_DEF) begin
                lsz = foot[cb-FOOTER_BYTES_DEF];
                if (lsz > 0 && lsz <= cb - base) begin
                    lb = cb - lsz;
                    if ((flg[lb] & (F_START | F_ALLOC)) == F_START) begin
                        unlink(lb, pg);
                        blk_size[lb] += blk_size[cb];
                        flg[cb] = 0;
                        cb = lb;
                    end
                end
            end
            // merge with a free right neighbor
            rb = cb + blk_size[cb];
            if (rb < base + SPAN && (flg[rb] & (F_START | F_ALLOC)) == F_START) begin
                unlink(rb, pg);
                blk_size[cb] += blk_size[rb];
                flg[rb] = 0;
            end
            set_tags(cb, blk_size[cb], 0);
            push(cb, pg);
            r.status = ST_OK;
            return r;
        endfunction

        // accepted input transaction
        function void note_command(logic cmd, int unsigned req, int unsigned addr);
            alloc_result_t r;
            accepted++;
            if (cmd == CMD_ALLOC) begin
                r = do_alloc(req);
                if (r.status == ST_OK) begin
                    live.push_back(r.payload);
                    last_payload = r.payload;
                end
            end else begin
                r = do_free(addr);
                if (r.status == ST_OK) begin
                    foreach (live[i])
                        if (live[i] == addr) begin
                            live.delete(i);
                            break;
                        end
                    freed.push_back(addr);
                    if (freed.size() > 16) void'(freed.pop_front());
                end
            end
            pending_q.push_back(r);
        endfunction

        // accepted result transaction
        function void check_result(logic [STATUS_W-1:0] st, logic [ADDR_IO_W-1:0] pa);
            alloc_result_t e;
            if (pending_q.size() == 0) begin
                $error("unexpected result: status %0d payload_address %0d", st, pa);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (st !== e.status) begin
                $error("status expected %0d actual %0d", e.status, st);
                errors++;
            end
            if (pa !== e.payload) begin
                $error("payload_address expected %0d actual %0d", e.payload, pa);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [0:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    alloc_scoreboard sb = new();
    bit quiet = 0;
    int idle_cycles = 0;

    coalescing_segregated_allocator uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always #1 aclk = ~aclk;

    // result monitor and stall watchdog
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tuser, m_axis_tdata);
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    // receiver: random stall bursts, one long hold-off
    initial begin
        bit held;
        held = 0;
        @(posedge aclk);
        forever begin
            if (!held && sb.accepted >= 300) begin
                held = 1;
                m_axis_tready <= 0;
                repeat (500) @(posedge aclk);
            end else if (quiet || $urandom_range(0, 2) != 0) begin
                m_axis_tready <= 1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end else begin
                m_axis_tready <= 0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    end

    // offer one command and wait until it is taken
    task automatic send_cmd(logic cmd, int unsigned req, int unsigned addr);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {addr[15:0], req[15:0]};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        sb.note_command(cmd, req, addr);
    endtask

    task automatic random_cmd();
        int unsigned pick, req;
        pick = $urandom_range(0, 99);
        if (sb.live.size() == 0 || pick < 55) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)      req = $urandom_range(0, 300);
            else if (pick < 90) req = $urandom_range(301, PAGE_BYTES_DEF);
            else if (pick < 95) req = PAGE_BYTES_DEF;
            else                req = $urandom_range(PAGE_BYTES_DEF + 1, 65535);
            send_cmd(CMD_ALLOC, req, $urandom_range(0, 65535));
        end else if (pick < 91)
            send_cmd(CMD_FREE, $urandom_range(0, 65535),
                     sb.live[$urandom_range(0, sb.live.size()-1)]);
        else if (pick < 95 && sb.freed.size() > 0)
            send_cmd(CMD_FREE, $urandom_range(0, 65535),
                     sb.freed[$urandom_range(0, sb.freed.size()-1)]);
        else
            send_cmd(CMD_FREE, $urandom_range(0, 65535), $urandom_range(0, 65535));
    endtask

    initial begin
        int unsigned whole[$];
        int unsigned a, b, c;
        aresetn <= 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1;

        // fill every page with a whole-page block, then one more finds no fit
        for (int i = 0; i < NUM_PAGES_DEF + 1; i++) begin
            send_cmd(CMD_ALLOC, PAGE_BYTES_DEF, 0);
            if (i < NUM_PAGES_DEF) whole.push_back(sb.last_payload);
        end
        foreach (whole[i]) send_cmd(CMD_FREE, 0, whole[i]);

        // size extremes and bad frees
        send_cmd(CMD_ALLOC, PAGE_BYTES_DEF + 1, 16'hffff);
        send_cmd(CMD_ALLOC, 16'hffff, 0);
        send_cmd(CMD_FREE, 0, 0);
        send_cmd(CMD_FREE, 16'hffff, HEADER_BYTES_DEF - 1);
        send_cmd(CMD_FREE, 0, 16'hffff);
        send_cmd(CMD_FREE, 0, ARENA + HEADER_BYTES_DEF);

        // zero-byte block, neighbors merging from both sides, double free
        send_cmd(CMD_ALLOC, 0, 0);
        a = sb.last_payload;
        send_cmd(CMD_ALLOC, 100, 0);
        b = sb.last_payload;
        send_cmd(CMD_ALLOC, 40, 0);
        c = sb.last_payload;
        send_cmd(CMD_FREE, 0, b + 8);
        send_cmd(CMD_FREE, 0, a);
        send_cmd(CMD_FREE, 0, c);
        send_cmd(CMD_FREE, 0, b);
        send_cmd(CMD_FREE, 0, b);

        for (int i = 0; i < RAND_ITEMS; i++) begin
            if (i == QUIET_AFTER) quiet = 1;
            random_cmd();
        end
        s_axis_tvalid <= 0;

        while (sb.pending_q.size() > 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### coalescing_segregated_allocator.f
rtl/csa_pkg.sv
rtl/csa_ram.sv
rtl/csa_clear.sv
rtl/csa_ctrl.sv
rtl/coalescing_segregated_allocator.sv
test/testbench.sv
